// ----- rtl/core/uoa_pkg.sv -----
// Shared types and constants for the undocumented-opcode execute unit.
// Holds mode codes, item structs and pipeline stage records.
// No dependencies.
package uoa_pkg;

  // Configuration port geometry
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_MAGIC = '0;

  // Constants used by the flag logic
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // Instruction modes
  typedef enum logic [3:0] {
    MODE_ALR = 4'd0,
    MODE_ANC = 4'd1,
    MODE_ARR = 4'd2,
    MODE_AXS = 4'd3,
    MODE_LXA = 4'd4,
    MODE_XAA = 4'd5,
    MODE_LAS = 4'd6,
    MODE_SHA = 4'd7,
    MODE_SHX = 4'd8,
    MODE_SHY = 4'd9,
    MODE_TAS = 4'd10
  } mode_t;

  // Source of the N and Z flags
  typedef enum logic [1:0] {
    NZ_KEEP = 2'd0,
    NZ_FROM_A = 2'd1,
    NZ_FROM_X = 2'd2
  } nz_sel_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  operand;
    logic [15:0] base_address;
    logic [7:0]  acc_in;
    logic [7:0]  x_in;
    logic [7:0]  y_in;
    logic [7:0]  sp_in;
    logic        n_in;
    logic        z_in;
    logic        c_in;
    logic        v_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  sp_out;
    logic        n_out;
    logic        z_out;
    logic        c_out;
    logic        v_out;
    logic        store_enable;
    logic [15:0] store_address;
    logic [7:0]  store_data;
  } out_item_t;

  // Stage 1: operands with the first logic terms and the low address sum
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] s;
    logic [7:0] op;
    logic       n;
    logic       z;
    logic       c;
    logic       v;
    logic [7:0] a_and_op;
    logic [7:0] a_and_x;
    logic [7:0] a_or_magic;
    logic [7:0] hi;
    logic [7:0] lo_sum;
    logic       lo_carry;
    logic [7:0] store_reg;
  } s1_t;

  // Stage 2: register results, carry and overflow, store fields
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  s;
    logic        n;
    logic        z;
    logic        c;
    logic        v;
    nz_sel_t     nz_sel;
    logic        st_en;
    logic [15:0] st_addr;
    logic [7:0]  st_data;
  } s2_t;

endpackage

// ----- rtl/core/uoa_if.sv -----
// Stream interfaces for the execute unit: instruction items in, results out.
// Depends on nothing; field names follow the item definitions in uoa_pkg.
interface uoa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [7:0]  operand;
  logic [15:0] base_address;
  logic [7:0]  acc_in;
  logic [7:0]  x_in;
  logic [7:0]  y_in;
  logic [7:0]  sp_in;
  logic        n_in;
  logic        z_in;
  logic        c_in;
  logic        v_in;

  modport source (
    output valid, mode, operand, base_address, acc_in, x_in, y_in, sp_in,
           n_in, z_in, c_in, v_in,
    input  ready
  );
  modport sink (
    input  valid, mode, operand, base_address, acc_in, x_in, y_in, sp_in,
           n_in, z_in, c_in, v_in,
    output ready
  );
endinterface

interface uoa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  sp_out;
  logic        n_out;
  logic        z_out;
  logic        c_out;
  logic        v_out;
  logic        store_enable;
  logic [15:0] store_address;
  logic [7:0]  store_data;

  modport source (
    output valid, acc_out, x_out, sp_out, n_out, z_out, c_out, v_out,
           store_enable, store_address, store_data,
    input  ready
  );
  modport sink (
    input  valid, acc_out, x_out, sp_out, n_out, z_out, c_out, v_out,
           store_enable, store_address, store_data,
    output ready
  );
endinterface

// ----- rtl/core/uoa_pipe.sv -----
// Three-stage execute pipeline for the undocumented opcodes.
// Depends on uoa_pkg for item structs, stage records and mode codes.
module uoa_pipe
  import uoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  input  logic [7:0] magic,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      v1, v2, v3;
  logic      adv1, adv2, adv3;
  s1_t       st1, st1_next;
  s2_t       st2, st2_next;
  out_item_t st3, st3_next;

  // A stage loads when it is empty or its content moves on
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage 1: logic terms, store register select and low address sum
  always_comb begin
    logic [7:0] idx;
    logic [8:0] lo;
    idx = (in_item.mode == MODE_SHY) ? in_item.x_in : in_item.y_in;
    lo  = {1'b0, in_item.base_address[7:0]} + {1'b0, idx};
    st1_next.mode       = in_item.mode;
    st1_next.a          = in_item.acc_in;
    st1_next.x          = in_item.x_in;
    st1_next.s          = in_item.sp_in;
    st1_next.op         = in_item.operand;
    st1_next.n          = in_item.n_in;
    st1_next.z          = in_item.z_in;
    st1_next.c          = in_item.c_in;
    st1_next.v          = in_item.v_in;
    st1_next.a_and_op   = in_item.acc_in & in_item.operand;
    st1_next.a_and_x    = in_item.acc_in & in_item.x_in;
    st1_next.a_or_magic = in_item.acc_in | magic;
    st1_next.hi         = in_item.base_address[15:8];
    st1_next.lo_sum     = lo[7:0];
    st1_next.lo_carry   = lo[8];
    st1_next.store_reg  = (in_item.mode == MODE_SHX) ? in_item.x_in : in_item.y_in;
  end

  // Stage 2: per-mode results, subtract for AXS, high-byte fix for SHX and SHY stores
  always_comb begin
    logic [8:0] diff;
    logic [7:0] h_new;
    logic [7:0] t;
    diff  = {1'b0, st1.a_and_x} - {1'b0, st1.op};
    h_new = st1.lo_carry ? (st1.hi & st1.store_reg) : st1.hi;
    t     = st1.op & st1.s;
    st2_next.a       = st1.a;
    st2_next.x       = st1.x;
    st2_next.s       = st1.s;
    st2_next.n       = st1.n;
    st2_next.z       = st1.z;
    st2_next.c       = st1.c;
    st2_next.v       = st1.v;
    st2_next.nz_sel  = NZ_KEEP;
    st2_next.st_en   = 1'b0;
    st2_next.st_addr = '0;
    st2_next.st_data = '0;
    case (st1.mode)
      MODE_ALR: begin
        st2_next.a      = {1'b0, st1.a_and_op[7:1]};
        st2_next.c      = st1.a_and_op[0];
        st2_next.nz_sel = NZ_FROM_A;
      end
      MODE_ANC: begin
        st2_next.a      = st1.a_and_op;
        st2_next.c      = st1.a_and_op[7];
        st2_next.nz_sel = NZ_FROM_A;
      end
      MODE_ARR: begin
        st2_next.a      = {st1.c, st1.a_and_op[7:1]};
        st2_next.c      = st1.a_and_op[7];
        st2_next.v      = st1.a_and_op[7] ^ st1.a_and_op[6];
        st2_next.nz_sel = NZ_FROM_A;
      end
      MODE_AXS: begin
        st2_next.x      = diff[7:0];
        st2_next.c      = !diff[8];
        st2_next.nz_sel = NZ_FROM_X;
      end
      MODE_LXA: begin
        st2_next.a      = st1.a_or_magic & st1.op;
        st2_next.x      = st1.a_or_magic & st1.op;
        st2_next.nz_sel = NZ_FROM_A;
      end
      MODE_XAA: begin
        st2_next.a      = st1.a_or_magic & st1.x & st1.op;
        st2_next.nz_sel = NZ_FROM_A;
      end
      MODE_LAS: begin
        st2_next.a = t;
        st2_next.x = t;
        st2_next.s = t;
      end
      MODE_SHA, MODE_TAS: begin
        st2_next.st_en   = 1'b1;
        st2_next.st_addr = {st1.hi + {7'd0, st1.lo_carry}, st1.lo_sum};
        st2_next.st_data = st1.a_and_x & (st1.hi + 8'd1);
        if (st1.mode == MODE_TAS) begin
          st2_next.s = st1.a_and_x;
        end
      end
      MODE_SHX, MODE_SHY: begin
        st2_next.st_en   = 1'b1;
        st2_next.st_addr = {h_new + {7'd0, st1.lo_carry}, st1.lo_sum};
        st2_next.st_data = st1.store_reg & (h_new + 8'd1);
      end
      default: begin
      end
    endcase
  end

  // Stage 3: N and Z flags, then the output register
  always_comb begin
    st3_next.acc_out       = st2.a;
    st3_next.x_out         = st2.x;
    st3_next.sp_out        = st2.s;
    st3_next.c_out         = st2.c;
    st3_next.v_out         = st2.v;
    st3_next.store_enable  = st2.st_en;
    st3_next.store_address = st2.st_addr;
    st3_next.store_data    = st2.st_data;
    case (st2.nz_sel)
      NZ_FROM_A: begin
        st3_next.n_out = st2.a[7];
        st3_next.z_out = (st2.a == BYTE_ZERO);
      end
      NZ_FROM_X: begin
        st3_next.n_out = st2.x[7];
        st3_next.z_out = (st2.x == BYTE_ZERO);
      end
      default: begin
        st3_next.n_out = st2.n;
        st3_next.z_out = st2.z;
      end
    endcase
  end

  // Advance valid bits; reset empties the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Hold payload while a stage is stalled
  always_ff @(posedge clk) begin
    if (adv1) st1 <= st1_next;
    if (adv2) st2 <= st2_next;
    if (adv3) st3 <= st3_next;
  end

  assign out_valid = v3;
  assign out_item  = st3;

endmodule

// ----- rtl/core/undocumented_opcode_alu.sv -----
// Each result passes through the stage registers st1, st2 and st3 in turn before the
// result transfer on the output channel.
// Throughput: one instruction per cycle while the output is not stalled; the three register
// stages advance independently, so a stalled output only blocks as far back as the pipeline is full.
// Reset (rst, synchronous, active high) empties the pipeline and clears unstable_magic to 0.
// Depends on uoa_pkg, uoa_in_if / uoa_out_if and uoa_pipe.
module undocumented_opcode_alu
  import uoa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  uoa_in_if.sink                in_ch,
  uoa_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [7:0] unstable_magic;
  logic       magic_sel;
  in_item_t   in_item;
  out_item_t  out_item;

  // Register decode on the word address
  assign magic_sel = (paddr[APB_ADDR_W-1:2] == REG_MAGIC);
  assign pready    = 1'b1;
  assign prdata    = magic_sel ? {{(APB_DATA_W-8){1'b0}}, unstable_magic} : '0;

  // Write the magic byte on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      unstable_magic <= '0;
    end else if (psel && penable && pwrite && pready && magic_sel) begin
      unstable_magic <= pwdata[7:0];
    end
  end

  // Gather the input transfer
  always_comb begin
    in_item.mode         = in_ch.mode;
    in_item.operand      = in_ch.operand;
    in_item.base_address = in_ch.base_address;
    in_item.acc_in       = in_ch.acc_in;
    in_item.x_in         = in_ch.x_in;
    in_item.y_in         = in_ch.y_in;
    in_item.sp_in        = in_ch.sp_in;
    in_item.n_in         = in_ch.n_in;
    in_item.z_in         = in_ch.z_in;
    in_item.c_in         = in_ch.c_in;
    in_item.v_in         = in_ch.v_in;
  end

  uoa_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .magic     (unstable_magic),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  // Spread the result onto the output channel
  assign out_ch.acc_out       = out_item.acc_out;
  assign out_ch.x_out         = out_item.x_out;
  assign out_ch.sp_out        = out_item.sp_out;
  assign out_ch.n_out         = out_item.n_out;
  assign out_ch.z_out         = out_item.z_out;
  assign out_ch.c_out         = out_item.c_out;
  assign out_ch.v_out         = out_item.v_out;
  assign out_ch.store_enable  = out_item.store_enable;
  assign out_ch.store_address = out_item.store_address;
  assign out_ch.store_data    = out_item.store_data;

endmodule

// ----- rtl/core/uoa_checker.sv -----
// Port-level checks for the undocumented-opcode execute unit, with the bind
// that attaches them to undocumented_opcode_alu. Uses no package.
module uoa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        store_enable,
  input logic [15:0] store_address,
  input logic [7:0]  store_data,
  input logic [7:0]  acc_out
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(store_address) &&
      $stable(store_data) && $stable(acc_out))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // With no result pending every stage has room
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  // Modes without a store drive zero store fields
  a_no_store_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_enable |-> store_address == 16'd0 && store_data == 8'd0)
    else $error("store fields nonzero without a store");

endmodule

bind undocumented_opcode_alu uoa_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .store_enable  (out_ch.store_enable),
  .store_address (out_ch.store_address),
  .store_data    (out_ch.store_data),
  .acc_out       (out_ch.acc_out)
);

// ----- bench/undocumented_opcode_alu_tb.sv -----
// Self-checking bench for undocumented_opcode_alu: drives instruction transfers,
// predicts each result in a scoreboard class and compares field by field.
// Depends on uoa_pkg, uoa_in_if / uoa_out_if and the undocumented_opcode_alu RTL.
`timescale 1ns / 1ps

module undocumented_opcode_alu_tb;
  import uoa_pkg::*;

  localparam int QUIET_LIMIT = 500;
  localparam logic [3:0] MODE_UNUSED_LO = 4'd11;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  localparam logic [APB_ADDR_W-1:0] MAGIC_ADDR = {REG_MAGIC, 2'b00};

  // Predicts register, flag and store results and tracks outstanding ones
  class alu_scoreboard;
    out_item_t pending[$];
    logic [7:0] magic;
    int errors;

    function new();
      magic = BYTE_ZERO;
      errors = 0;
    endfunction

    // Index-AND-high store; the high byte is corrupted on a page cross
    function void index_store(input logic [15:0] base, input logic [7:0] idx,
                              input logic [7:0] src, output logic [15:0] addr,
                              output logic [7:0] data);
      logic [15:0] sum;
      logic [7:0] h;
      sum = base + idx;
      h = base[15:8];
      if (sum[15:8] != h) h = h & src;
      data = src & (h + 8'd1);
      addr = {h, base[7:0]} + idx;
    endfunction

    function out_item_t execute_opcode(in_item_t it);
      out_item_t r;
      logic [7:0] a, x, s, t, hi;
      logic n, z, c, v, nz_from_a;
      r = '0;
      a = it.acc_in;
      x = it.x_in;
      s = it.sp_in;
      n = it.n_in;
      z = it.z_in;
      c = it.c_in;
      v = it.v_in;
      hi = it.base_address[15:8];
      nz_from_a = 1'b0;
      case (it.mode)
        MODE_ALR: begin
          t = a & it.operand;
          c = t[0];
          a = t >> 1;
          nz_from_a = 1'b1;
        end
        MODE_ANC: begin
          a = a & it.operand;
          c = a[7];
          nz_from_a = 1'b1;
        end
        MODE_ARR: begin
          t = a & it.operand;
          a = {c, t[7:1]};
          c = a[6];
          v = a[6] ^ a[5];
          nz_from_a = 1'b1;
        end
        MODE_AXS: begin
          t = a & x;
          c = (t >= it.operand);
          x = t - it.operand;
          n = x[7];
          z = (x == BYTE_ZERO);
        end
        MODE_LXA: begin
          a = (a | magic) & it.operand;
          x = a;
          nz_from_a = 1'b1;
        end
        MODE_XAA: begin
          a = (a | magic) & x & it.operand;
          nz_from_a = 1'b1;
        end
        MODE_LAS: begin
          t = it.operand & s;
          a = t;
          x = t;
          s = t;
        end
        MODE_SHA, MODE_TAS: begin
          if (it.mode == MODE_TAS) s = a & x;
          r.store_enable = 1'b1;
          r.store_address = it.base_address + it.y_in;
          r.store_data = a & x & (hi + 8'd1);
        end
        MODE_SHX: begin
          r.store_enable = 1'b1;
          index_store(it.base_address, it.y_in, x, r.store_address, r.store_data);
        end
        MODE_SHY: begin
          r.store_enable = 1'b1;
          index_store(it.base_address, x, it.y_in, r.store_address, r.store_data);
        end
        default: ;
      endcase
      if (nz_from_a) begin
        n = a[7];
        z = (a == BYTE_ZERO);
      end
      r.acc_out = a;
      r.x_out = x;
      r.sp_out = s;
      r.n_out = n;
      r.z_out = z;
      r.c_out = c;
      r.v_out = v;
      return r;
    endfunction

    function void note_instruction(in_item_t it);
      pending.push_back(execute_opcode(it));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("acc_out", want.acc_out, got.acc_out);
      compare_field("x_out", want.x_out, got.x_out);
      compare_field("sp_out", want.sp_out, got.sp_out);
      compare_field("n_out", want.n_out, got.n_out);
      compare_field("z_out", want.z_out, got.z_out);
      compare_field("c_out", want.c_out, got.c_out);
      compare_field("v_out", want.v_out, got.v_out);
      compare_field("store_enable", want.store_enable, got.store_enable);
      compare_field("store_address", want.store_address, got.store_address);
      compare_field("store_data", want.store_data, got.store_data);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  uoa_in_if in_bus ();
  uoa_out_if out_bus ();

  alu_scoreboard board;
  bit tx_idle;
  bit rx_idle;

  undocumented_opcode_alu i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result side: random stall bursts while rx_idle is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Check result transfers and watch for a stalled run
  always @(posedge clk) begin
    int quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        board.check_result({out_bus.acc_out, out_bus.x_out, out_bus.sp_out,
                            out_bus.n_out, out_bus.z_out, out_bus.c_out, out_bus.v_out,
                            out_bus.store_enable, out_bus.store_address,
                            out_bus.store_data});
      end
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("undocumented_opcode_alu_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic in_item_t instr(logic [3:0] mode, logic [7:0] op, logic [15:0] base,
                                     logic [7:0] a, logic [7:0] x, logic [7:0] y,
                                     logic [7:0] s, logic [3:0] nzcv);
    in_item_t it;
    it.mode = mode;
    it.operand = op;
    it.base_address = base;
    it.acc_in = a;
    it.x_in = x;
    it.y_in = y;
    it.sp_in = s;
    {it.n_in, it.z_in, it.c_in, it.v_in} = nzcv;
    return it;
  endfunction

  // Bias toward the corner bytes now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h40;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_instruction();
    in_item_t it;
    if ($urandom_range(0, 99) < 94) it.mode = 4'($urandom_range(0, MODE_TAS));
    else it.mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    it.operand = pick_byte();
    it.base_address = 16'($urandom);
    // Push the base toward page and address-space edges
    case ($urandom_range(0, 7))
      0: it.base_address[15:8] = 8'hFF;
      1: it.base_address[7:0] = 8'hFF;
      2: it.base_address[7:0] = 8'($urandom_range(8'hC0, 8'hFF));
      default: ;
    endcase
    it.acc_in = pick_byte();
    it.x_in = pick_byte();
    it.y_in = pick_byte();
    it.sp_in = pick_byte();
    {it.n_in, it.z_in, it.c_in, it.v_in} = 4'($urandom);
    return it;
  endfunction

  // Present one instruction and hold it until the transfer
  task automatic send_instruction(input in_item_t it);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode <= it.mode;
    in_bus.operand <= it.operand;
    in_bus.base_address <= it.base_address;
    in_bus.acc_in <= it.acc_in;
    in_bus.x_in <= it.x_in;
    in_bus.y_in <= it.y_in;
    in_bus.sp_in <= it.sp_in;
    in_bus.n_in <= it.n_in;
    in_bus.z_in <= it.z_in;
    in_bus.c_in <= it.c_in;
    in_bus.v_in <= it.v_in;
    do @(posedge clk); while (!in_bus.ready);
    board.note_instruction(it);
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result has arrived
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_magic(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAGIC_ADDR;
    pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.magic = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [7:0] magic;
    board = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.mode <= MODE_ALR;
    in_bus.operand <= '0;
    in_bus.base_address <= '0;
    in_bus.acc_in <= '0;
    in_bus.x_in <= '0;
    in_bus.y_in <= '0;
    in_bus.sp_in <= '0;
    in_bus.n_in <= 1'b0;
    in_bus.z_in <= 1'b0;
    in_bus.c_in <= 1'b0;
    in_bus.v_in <= 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_magic(8'h00);

    // Directed: each mode, flag corners, borrow, page crosses and wrap
    send_instruction(instr(MODE_ALR, 8'hFF, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'h00, 4'b0000));
    send_instruction(instr(MODE_ALR, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'b1111));
    send_instruction(instr(MODE_ANC, 8'hFF, 16'h1234, 8'h80, 8'h11, 8'h22, 8'h33, 4'b0100));
    send_instruction(instr(MODE_ANC, 8'h0F, 16'h1234, 8'h7F, 8'h11, 8'h22, 8'h33, 4'b1011));
    send_instruction(instr(MODE_ARR, 8'hFF, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'h00, 4'b0010));
    send_instruction(instr(MODE_ARR, 8'h40, 16'h0000, 8'h40, 8'h00, 8'h00, 8'h00, 4'b0001));
    send_instruction(instr(MODE_AXS, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'h00, 8'h00, 4'b0101));
    send_instruction(instr(MODE_AXS, 8'h05, 16'h0000, 8'h0F, 8'h03, 8'h00, 8'h00, 4'b0010));
    send_instruction(instr(MODE_AXS, 8'h3C, 16'h0000, 8'h3C, 8'hFF, 8'h00, 8'h00, 4'b1000));
    send_instruction(instr(MODE_LXA, 8'hFF, 16'h0000, 8'h00, 8'h12, 8'h00, 8'h00, 4'b1111));
    send_instruction(instr(MODE_XAA, 8'h3C, 16'h0000, 8'hFF, 8'hF0, 8'h00, 8'h00, 4'b0000));
    send_instruction(instr(MODE_LAS, 8'hFF, 16'hABCD, 8'h55, 8'h66, 8'h77, 8'h00, 4'b1111));
    send_instruction(instr(MODE_LAS, 8'hAA, 16'hABCD, 8'h55, 8'h66, 8'h77, 8'hFF, 4'b0000));
    send_instruction(instr(MODE_SHA, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 4'b0000));
    send_instruction(instr(MODE_SHA, 8'h00, 16'h1234, 8'hFF, 8'h3F, 8'h00, 8'h00, 4'b1010));
    send_instruction(instr(MODE_TAS, 8'h00, 16'h80F0, 8'hF3, 8'h5F, 8'h20, 8'h99, 4'b0101));
    send_instruction(instr(MODE_SHX, 8'h00, 16'h12F0, 8'h00, 8'h0F, 8'h20, 8'h00, 4'b0000));
    send_instruction(instr(MODE_SHX, 8'h00, 16'h1200, 8'h00, 8'hFF, 8'h10, 8'h00, 4'b0000));
    send_instruction(instr(MODE_SHY, 8'h00, 16'h34FF, 8'h00, 8'h01, 8'hF0, 8'h00, 4'b0000));
    send_instruction(instr(MODE_SHY, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'b1111));
    send_instruction(instr(MODE_UNUSED_LO, 8'h5A, 16'h5A5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A,
                           4'b1010));
    send_instruction(instr(MODE_UNUSED_HI, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                           4'b1111));
    send_instruction(instr(MODE_ALR, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 4'b0000));

    // Random phases; each one sets a magic byte and an idle pattern before it starts
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      repeat (4) @(negedge clk);
      case (phase)
        0: magic = 8'hFF;
        2: magic = 8'h00;
        3: magic = 8'h01;
        5: magic = 8'h80;
        default: magic = 8'($urandom);
      endcase
      write_magic(magic);
      tx_idle = (phase == 0 || phase == 1 || phase == 3);
      rx_idle = (phase == 0 || phase == 2 || phase == 3);
      for (int k = 0; k < 130; k++) begin
        if (phase == 2 && k == 65) wait_for_results();
        send_instruction(random_instruction());
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("undocumented_opcode_alu_tb: PASS");
    end else begin
      $display("undocumented_opcode_alu_tb: FAIL");
    end
    $finish;
  end

endmodule
